### rtl/crc16fr_pkg.sv
// ============================================================================
// crc16fr_pkg
// Types, codes and the CRC table function for the CRC-16 frame receiver.
// ============================================================================
`default_nettype none

package crc16fr_pkg;

    // Frame layout and protocol constants
    localparam logic [7:0]  PREAMBLE          = 8'h55;
    localparam logic [15:0] CRC_POLY          = 16'hC86C;
    localparam logic [7:0]  TYPE_POS          = 8'd0;
    localparam logic [7:0]  ADDRESS_POS       = 8'd1;
    localparam logic [7:0]  LENGTH_POS        = 8'd3;
    localparam logic [15:0] BROADCAST_ADDRESS = 16'h0000;

    // Address match list
    localparam int ADDRESS_SLOTS_DEFAULT = 5;
    localparam int NUM_ADDR_REGS         = 5;

    // Configuration port
    localparam int              CFG_INDEX_W       = 3;
    localparam int              CFG_DATA_W        = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_TIMEOUT = 3'd5;
    localparam logic [15:0]     GAP_TIMEOUT_RESET = 16'd10;

    typedef enum logic [2:0] {
        EV_IGNORED     = 3'd0,
        EV_FRAME_START = 3'd1,
        EV_BYTE_STORED = 3'd2,
        EV_ACCEPTED    = 3'd3,
        EV_CRC_ERROR   = 3'd4,
        EV_NOT_ADDR    = 3'd5
    } event_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [15:0] idle_time;
    } rx_req_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [7:0]  frame_type;
        logic [15:0] frame_address;
    } rx_res_t;

    // One entry of the MSB-first CRC table: eight shift steps on one byte
    function automatic logic [15:0] crc_table(input logic [7:0] idx);
        logic [15:0] c;
        c = {idx, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/crc16_frame_receiver.sv
// ============================================================================
// crc16_frame_receiver
// Serial frame receiver with CRC-16 check and address filter.
// ============================================================================
// Takes one request per cycle (a received byte plus the idle time since the
// byte before it) unless stalled and returns exactly one result per request.
// The result is offered once it has been loaded into the result register. A
// request sits in an input register; from there one table CRC step, the field
// capture and the address compares run combinationally into the result
// register, so the sustained rate is one request per clock without a stall.
// The result register and the input register decouple the two sides: while a
// result waits to be taken, one more request is still accepted. Configuration
// is a plain write port: index 0 is the own address, 1..4 the group addresses
// (zero is an empty slot), 5 the gap timeout (reset 10); other indexes are
// dropped. Write only while idle.
// ============================================================================
`default_nettype none

module crc16_frame_receiver
    import crc16fr_pkg::*;
#(
    parameter int ADDRESS_SLOTS = ADDRESS_SLOTS_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // request channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire rx_req_t                in_data,
    // result channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output rx_res_t                     out_data,
    // configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // Slots past the address registers read as zero, which only repeats the
    // broadcast match, so compare against the stored ones alone.
    localparam int SlotCount = (ADDRESS_SLOTS < NUM_ADDR_REGS) ? ADDRESS_SLOTS
                                                               : NUM_ADDR_REGS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] addr_reg [NUM_ADDR_REGS];
    logic [15:0] gap_timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ADDR_REGS; i++)
                addr_reg[i] <= '0;
            gap_timeout_reg <= GAP_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index < REG_GAP_TIMEOUT)
                addr_reg[cfg_index] <= cfg_wdata;
            else if (cfg_index == REG_GAP_TIMEOUT)
                gap_timeout_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic    req_valid_reg;
    rx_req_t req_reg;
    logic    out_valid_reg;
    rx_res_t res_reg;
    logic    res_free;
    logic    advance;

    // Result register can load when empty or being drained this cycle
    assign res_free = !out_valid_reg || !out_stall;
    assign advance  = req_valid_reg && res_free;
    // Hold off the sender only when the input register cannot move on
    assign in_stall = req_valid_reg && !res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (!in_stall)
            req_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            req_reg <= in_data;
    end

    // ------------------------------------------------------------------
    // Frame state
    // ------------------------------------------------------------------
    logic        receiving_reg,  receiving_next;
    logic [7:0]  count_reg,      count_next;
    logic [15:0] crc_reg,        crc_next;
    logic [7:0]  length_reg,     length_next;
    logic [7:0]  type_reg,       type_next;
    logic [15:0] dest_reg,       dest_next;
    logic [7:0]  prev_reg,       prev_next;
    rx_res_t     res_next;

    logic [7:0]  b;
    logic        resync;
    logic        past_header;
    logic        addr_hit;

    always_comb
    begin
        b              = req_reg.rx_byte;
        resync         = (req_reg.idle_time >= gap_timeout_reg) || !receiving_reg;

        receiving_next = receiving_reg;
        count_next     = count_reg;
        crc_next       = crc_reg;
        length_next    = length_reg;
        type_next      = type_reg;
        dest_next      = dest_reg;
        prev_next      = prev_reg;
        past_header    = 1'b0;
        addr_hit       = 1'b0;

        res_next.data_byte = b;

        if (resync)
        begin
            // Drop any partial frame; open a new one only on the preamble
            count_next     = '0;
            crc_next       = '0;
            length_next    = '0;
            type_next      = '0;
            dest_next      = '0;
            receiving_next = (b == PREAMBLE);
            res_next.event_res     = receiving_next ? EV_FRAME_START : EV_IGNORED;
            res_next.byte_index    = '0;
            res_next.frame_type    = '0;
            res_next.frame_address = '0;
        end
        else
        begin
            // Capture the header field at this position
            if (count_reg == TYPE_POS)
                type_next = b;
            else if (count_reg == ADDRESS_POS)
                dest_next = {dest_reg[15:8], b};
            else if (count_reg == ADDRESS_POS + 8'd1)
                dest_next = {b, dest_reg[7:0]};
            else if (count_reg == LENGTH_POS)
                length_next = b;

            count_next  = count_reg + 8'd1;
            past_header = count_next > LENGTH_POS;

            // Skip the CRC for the two trailing check bytes
            if (!(past_header && ({1'b0, count_next} + 9'd1 >= {1'b0, length_next})))
                crc_next = crc_table(crc_reg[15:8] ^ b) ^ {crc_reg[7:0], 8'h00};

            addr_hit = (dest_next == BROADCAST_ADDRESS);
            for (int i = 0; i < SlotCount; i++)
                if (addr_reg[i] == dest_next)
                    addr_hit = 1'b1;

            res_next.event_res = EV_BYTE_STORED;
            if (past_header && (count_next >= length_next))
            begin
                // Close the frame: address filter wins over the CRC check
                receiving_next = 1'b0;
                if (!addr_hit)
                    res_next.event_res = EV_NOT_ADDR;
                else if ((crc_next[7:0] == b) && (crc_next[15:8] == prev_reg))
                    res_next.event_res = EV_ACCEPTED;
                else
                    res_next.event_res = EV_CRC_ERROR;
            end
            prev_next = b;

            res_next.byte_index    = count_reg;
            res_next.frame_type    = type_next;
            res_next.frame_address = dest_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            count_reg     <= '0;
            crc_reg       <= '0;
            length_reg    <= '0;
            type_reg      <= '0;
            dest_reg      <= '0;
            prev_reg      <= '0;
        end
        else if (advance)
        begin
            receiving_reg <= receiving_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            length_reg    <= length_next;
            type_reg      <= type_next;
            dest_reg      <= dest_next;
            prev_reg      <= prev_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_free)
            out_valid_reg <= req_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

endmodule

`default_nettype wire

### rtl/crc16fr_checker.sv
// ============================================================================
// crc16fr_checker
// Port-level assertions for the CRC-16 frame receiver, bound to the top level.
// ============================================================================
`default_nettype none

module crc16fr_checker
    import crc16fr_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    out_valid,
    input wire logic    out_stall,
    input wire rx_res_t out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Outside a frame the frame fields read as zero
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.event_res == EV_IGNORED ||
                      out_data.event_res == EV_FRAME_START)
        |-> out_data.byte_index == '0 && out_data.frame_type == '0 &&
            out_data.frame_address == '0)
        else $error("frame fields not cleared outside a frame");

    // A frame opens on the preamble alone
    a_start_preamble: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_res == EV_FRAME_START
        |-> out_data.data_byte == PREAMBLE)
        else $error("frame start without preamble");

    // A preamble during resync is never ignored
    a_ignored_not_preamble: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_res == EV_IGNORED
        |-> out_data.data_byte != PREAMBLE)
        else $error("preamble ignored");

endmodule

bind crc16_frame_receiver crc16fr_checker u_crc16fr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

### tb/tb_crc16_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_crc16_frame_receiver
// Self-checking bench for the CRC-16 serial frame receiver. A local predictor
// tracks frame state, CRC and the address filter. Each accepted request pushes
// one predicted result, and each taken result is checked field by field
// against the oldest prediction. Directed frames come first, then random frame
// traffic under several filter and timeout settings, with random bursts of
// valid and stall idling on both channels.
// ----------------------------------------------------------------------------
module tb_crc16_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import crc16fr_pkg::*;

    // Register indexes that the package leaves unnamed
    localparam logic [CFG_INDEX_W-1:0] REG_GROUP_ADDRESS_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GROUP_ADDRESS_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GROUP_ADDRESS_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GROUP_ADDRESS_4 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6         = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7         = 3'd7;

    localparam int DRAIN_CYCLES  = 8;   // result path is two stages deep
    localparam int MAX_REPORTS   = 10;
    localparam int BURST_MAX     = 18;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 240;
    localparam logic [7:0] SHORT_ADDR_HI = 8'hA7;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    rx_req_t                in_data;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    rx_res_t                out_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Mirror of the configuration registers
    logic [15:0] addr_slots [NUM_ADDR_REGS];
    logic [15:0] gap_limit;

    // Predicted receiver state
    bit          frame_open;
    logic [7:0]  frame_count;
    logic [15:0] frame_crc;
    logic [7:0]  frame_len;
    logic [7:0]  frame_kind;
    logic [15:0] frame_dest;
    logic [7:0]  last_stored;

    rx_res_t pending_results [$];
    int      fail_count = 0;
    int      items_sent = 0;
    bit      idle_enable;
    int      stall_left = 0;

    crc16_frame_receiver u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Advance the CRC by one byte, bit-serial, MSB first
    function automatic logic [15:0] crc16_push(input logic [15:0] crc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0};
            if (fb)
                crc = crc ^ CRC_POLY;
        end
        return crc;
    endfunction

    // Apply one request to the predicted state and return the result it causes
    function automatic rx_res_t predict_rx_result(input rx_req_t req);
        rx_res_t    res;
        logic [7:0] b;
        logic [7:0] pos;
        int         cnt;
        bit         hit;
        b             = req.rx_byte;
        res.data_byte = b;

        // A long gap or a closed frame drops everything and hunts for the preamble
        if (req.idle_time >= gap_limit || !frame_open)
        begin
            frame_count       = 8'd0;
            frame_crc         = 16'h0000;
            frame_len         = 8'd0;
            frame_kind        = 8'd0;
            frame_dest        = 16'h0000;
            frame_open        = (b == PREAMBLE);
            res.event_res     = frame_open ? EV_FRAME_START : EV_IGNORED;
            res.byte_index    = 8'd0;
            res.frame_type    = 8'd0;
            res.frame_address = 16'h0000;
            return res;
        end

        // Capture header fields by position
        pos = frame_count;
        if (pos == TYPE_POS)
            frame_kind = b;
        else if (pos == ADDRESS_POS)
            frame_dest[7:0] = b;
        else if (pos == ADDRESS_POS + 8'd1)
            frame_dest[15:8] = b;
        else if (pos == LENGTH_POS)
            frame_len = b;

        frame_count = pos + 8'd1;
        cnt         = int'(frame_count);

        // The two trailing CRC bytes stay out of the running CRC
        if (!(cnt > LENGTH_POS && cnt + 1 >= frame_len))
            frame_crc = crc16_push(frame_crc, b);

        res.event_res = EV_BYTE_STORED;
        if (cnt > LENGTH_POS && cnt >= frame_len)
        begin
            frame_open = 1'b0;
            hit        = (frame_dest == BROADCAST_ADDRESS);
            for (int i = 0; i < ADDRESS_SLOTS_DEFAULT && i < NUM_ADDR_REGS; i++)
                if (addr_slots[i] == frame_dest)
                    hit = 1'b1;
            // The address filter outranks the CRC verdict
            if (!hit)
                res.event_res = EV_NOT_ADDR;
            else if (frame_crc[7:0] == b && frame_crc[15:8] == last_stored)
                res.event_res = EV_ACCEPTED;
            else
                res.event_res = EV_CRC_ERROR;
        end
        last_stored = b;

        res.byte_index    = pos;
        res.frame_type    = frame_kind;
        res.frame_address = frame_dest;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Checking: compare taken results first, then predict the accepted request.
    // A request accepted at this edge cannot have its result out at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rx_res_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: ev=%0d byte=%02h idx=%0d type=%02h addr=%04h",
                                 out_data.event_res, out_data.data_byte, out_data.byte_index,
                                 out_data.frame_type, out_data.frame_address);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.event_res !== want.event_res ||
                        out_data.data_byte !== want.data_byte ||
                        out_data.byte_index !== want.byte_index ||
                        out_data.frame_type !== want.frame_type ||
                        out_data.frame_address !== want.frame_address)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch: expected ev=%0d byte=%02h idx=%0d type=%02h addr=%04h, got ev=%0d byte=%02h idx=%0d type=%02h addr=%04h",
                                     want.event_res, want.data_byte, want.byte_index,
                                     want.frame_type, want.frame_address,
                                     out_data.event_res, out_data.data_byte,
                                     out_data.byte_index, out_data.frame_type,
                                     out_data.frame_address);
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(predict_rx_result(in_data));
        end
    end

    // Result-side back-pressure: random stall bursts; a burst is cut off as soon
    // as idling is switched off
    always @(posedge clk)
    begin
        if (!idle_enable)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, BURST_MAX) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Request and configuration drivers
    // ------------------------------------------------------------------------

    // Offer one request and hold it until taken; valid stays high for the next
    task automatic send_rx(input logic [7:0] b, input logic [15:0] idle);
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, idle};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register and mirror it; write enable is left for the caller to drop
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx < NUM_ADDR_REGS)
            addr_slots[idx] = val;
        else if (idx == REG_GAP_TIMEOUT)
            gap_limit = val;
    endtask

    // Reprogram the whole filter while idle; the spare indexes must be ignored
    task automatic program_filter(input logic [15:0] own, input logic [15:0] g1,
                                  input logic [15:0] g2, input logic [15:0] g3,
                                  input logic [15:0] g4, input logic [15:0] timeout);
        drain_results();
        write_reg(REG_OWN_ADDRESS, own);
        write_reg(REG_GROUP_ADDRESS_1, g1);
        write_reg(REG_GROUP_ADDRESS_2, g2);
        write_reg(REG_GROUP_ADDRESS_3, g3);
        write_reg(REG_GROUP_ADDRESS_4, g4);
        write_reg(REG_GAP_TIMEOUT, timeout);
        write_reg(REG_SPARE_6, 16'($urandom_range(0, 65535)));
        write_reg(REG_SPARE_7, 16'($urandom_range(0, 65535)));
        cfg_we <= 1'b0;
    endtask

    // Idle time between bytes of one frame: mostly under the timeout
    function automatic logic [15:0] inner_idle();
        if (gap_limit == 16'd0 || $urandom_range(0, 59) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, gap_limit - 1));
    endfunction

    // Send preamble plus a frame; lengths of six and up carry a proper CRC trailer
    task automatic send_frame(input logic [7:0] kind, input logic [15:0] dest,
                              input logic [7:0] len, input bit corrupt);
        logic [7:0]  body [$];
        logic [15:0] crc;
        int          tail;
        body.push_back(kind);
        body.push_back(dest[7:0]);
        body.push_back(dest[15:8]);
        body.push_back(len);
        if (len == 8'd5)
            body.push_back(8'($urandom_range(0, 255)));
        else if (len > 8'd5)
        begin
            for (int i = 4; i < len - 2; i++)
                body.push_back(8'($urandom_range(0, 255)));
            crc = 16'h0000;
            foreach (body[i])
                crc = crc16_push(crc, body[i]);
            body.push_back(crc[15:8]);
            body.push_back(crc[7:0]);
        end
        if (corrupt)
        begin
            tail       = body.size() - 1;
            body[tail] = body[tail] ^ (8'h01 << $urandom_range(0, 7));
        end
        send_rx(PREAMBLE, 16'($urandom_range(0, 65535)));
        foreach (body[i])
            send_rx(body[i], inner_idle());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: timeout 10, every slot empty, so only broadcast gets through
    task automatic test_reset_defaults();
        send_frame(8'h10, BROADCAST_ADDRESS, 8'd6, 1'b0);
    endtask

    // Group slot match with a good CRC, then an unknown address with its last byte flipped
    task automatic test_address_filter();
        program_filter(16'h1234, 16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'hFFFF);
        send_frame(8'hFF, 16'hFFFF, 8'd6, 1'b0);
        send_frame(8'h00, 16'h4321, 8'd4, 1'b1);
    endtask

    // Gap just under the timeout keeps the frame, a gap at the timeout drops it
    task automatic test_resync();
        send_rx(PREAMBLE, 16'd0);
        send_rx(8'h00, 16'hFFFE);
        send_rx(8'hFF, 16'hFFFF);
        send_rx(PREAMBLE, 16'hFFFF);
        send_rx(8'h5A, 16'd0);
    endtask

    // Short frame closing on the length byte: the address high byte and the
    // length byte act as the CRC trailer. Search for a header that passes.
    task automatic test_short_length();
        logic [15:0] crc;
        logic [15:0] hit_addr;
        logic [7:0]  hit_kind;
        logic [7:0]  hit_len;
        bit          found;
        found    = 1'b0;
        hit_addr = {SHORT_ADDR_HI, 8'h00};
        hit_kind = 8'h00;
        hit_len  = 8'd4;
        for (int l = 0; l <= 4 && !found; l++)
            for (int k = 0; k < 256 && !found; k++)
                for (int a = 0; a < 256 && !found; a++)
                begin
                    crc = crc16_push(crc16_push(crc16_push(16'h0000, k[7:0]), a[7:0]),
                                     SHORT_ADDR_HI);
                    if (crc == {SHORT_ADDR_HI, l[7:0]})
                    begin
                        found    = 1'b1;
                        hit_addr = {SHORT_ADDR_HI, a[7:0]};
                        hit_kind = k[7:0];
                        hit_len  = l[7:0];
                    end
                end
        program_filter(hit_addr, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd1);
        send_frame(hit_kind, hit_addr, hit_len, 1'b0);
    endtask

    // Zero timeout: every byte resyncs, so nothing is ever stored
    task automatic test_zero_timeout();
        program_filter(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_rx(PREAMBLE, 16'd0);
        send_rx(8'h80, 16'd0);
        send_rx(PREAMBLE, 16'd0);
    endtask

    // Random frames under changing filters; mostly well formed, some noise and
    // truncated frames. The final phase runs with no idling on either side.
    task automatic test_random_traffic();
        logic [15:0] slot_val [NUM_ADDR_REGS];
        logic [15:0] timeout;
        logic [15:0] dest;
        logic [7:0]  len;
        int          start;
        int          target;
        int          pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (int s = 0; s < NUM_ADDR_REGS; s++)
            begin
                pick = $urandom_range(0, 7);
                if (phase == 0 || pick == 0)
                    slot_val[s] = 16'hFFFF;
                else if (pick < 3)
                    slot_val[s] = 16'h0000;
                else
                    slot_val[s] = 16'($urandom_range(0, 65535));
            end
            case ($urandom_range(0, 5))
                0:       timeout = 16'd1;
                1:       timeout = 16'hFFFF;
                2:       timeout = 16'($urandom_range(2, 64));
                3:       timeout = 16'($urandom_range(0, 65535));
                default: timeout = 16'($urandom_range(8, 2000));
            endcase
            if (phase == 0)
                timeout = 16'hFFFF;
            else if (phase == 1)
                timeout = 16'h0000;
            program_filter(slot_val[0], slot_val[1], slot_val[2], slot_val[3],
                           slot_val[4], timeout);

            idle_enable = (phase != RANDOM_PHASES - 1);
            target      = (timeout == 16'h0000) ? 60 : PHASE_ITEMS;
            start       = items_sent;
            while (items_sent - start < target)
            begin
                // Toggle idling now and then so quiet stretches occur too
                if (phase != RANDOM_PHASES - 1 && $urandom_range(0, 39) == 0)
                    idle_enable = !idle_enable;
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    case ($urandom_range(0, 9))
                        0, 1:       dest = addr_slots[REG_OWN_ADDRESS];
                        2, 3, 4, 5: dest = addr_slots[3'($urandom_range(1, NUM_ADDR_REGS - 1))];
                        6:          dest = BROADCAST_ADDRESS;
                        default:    dest = 16'($urandom_range(0, 65535));
                    endcase
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        len = 8'($urandom_range(6, 24));
                    else if (pick < 85)
                        len = 8'($urandom_range(0, 5));
                    else if (pick < 97)
                        len = 8'($urandom_range(25, 64));
                    else
                        len = 8'($urandom_range(65, 255));
                    send_frame(8'($urandom_range(0, 255)), dest, len,
                               $urandom_range(0, 3) == 0);
                end
                else if (pick < 90)
                begin
                    repeat ($urandom_range(1, 6))
                        send_rx(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
                end
                else
                begin
                    // Truncated frame: the next preamble may land inside it
                    send_rx(PREAMBLE, 16'($urandom_range(0, 65535)));
                    repeat ($urandom_range(1, 5))
                        send_rx(8'($urandom_range(0, 255)), inner_idle());
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        idle_enable = 1'b1;
        for (int s = 0; s < NUM_ADDR_REGS; s++)
            addr_slots[s] = 16'h0000;
        gap_limit   = GAP_TIMEOUT_RESET;
        frame_open  = 1'b0;
        frame_count = 8'd0;
        frame_crc   = 16'h0000;
        frame_len   = 8'd0;
        frame_kind  = 8'd0;
        frame_dest  = 16'h0000;
        last_stored = 8'd0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_address_filter();
        test_resync();
        test_short_length();
        test_zero_timeout();
        test_random_traffic();
        drain_results();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
